// ===== sv/recursive_length_prefix_decoder_assert.svh =====
// Assertion macros shared by the recursive length prefix decoder.
`ifndef RECURSIVE_LENGTH_PREFIX_DECODER_ASSERT_SVH
`define RECURSIVE_LENGTH_PREFIX_DECODER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define RLPD_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define RLPD_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/rlpd_pkg.sv =====
// Types and constants of the recursive length prefix decoder.
package rlpd_pkg;

   localparam int LEN_W = 7;

   localparam logic [LEN_W-1:0] START_LENGTH = 7'd2;
   localparam logic [LEN_W-1:0] PREFIX_SAT   = 7'd127;

   typedef enum logic [1:0] {
      PH_LENGTH = 2'd0,
      PH_CHECK  = 2'd1,
      PH_DATA   = 2'd2
   } phase_type;

   typedef struct packed {
      phase_type        phase;
      logic [LEN_W-1:0] bits_left;
      logic [LEN_W-1:0] prefix_value;
      logic [LEN_W-1:0] data_bits;
   } ctrl_type;

   typedef struct packed {
      logic [LEN_W-1:0] value_bits;
      logic             length_error;
   } res_type;

   localparam ctrl_type CTRL_RESTART = '{
      phase:        PH_LENGTH,
      bits_left:    START_LENGTH,
      prefix_value: '0,
      data_bits:    '0
   };

endpackage

// ===== sv/rlpd_bit_step.sv =====
// One bit step of the decoder: consumes a single code bit and updates the state.
module rlpd_bit_step #(
   parameter int VALUE_BITS = 64
) (
   input  rlpd_pkg::ctrl_type      ctrl_cur,
   input  logic [VALUE_BITS-1:0]   acc_cur,
   input  logic                    done_cur,
   input  logic [VALUE_BITS-1:0]   value_cur,
   input  rlpd_pkg::res_type       res_cur,
   input  logic                    code_bit,
   output rlpd_pkg::ctrl_type      ctrl_nxt,
   output logic [VALUE_BITS-1:0]   acc_nxt,
   output logic                    done_nxt,
   output logic [VALUE_BITS-1:0]   value_nxt,
   output rlpd_pkg::res_type       res_nxt
);

   localparam logic [rlpd_pkg::LEN_W-1:0] MaxLen = rlpd_pkg::LEN_W'(VALUE_BITS);

   logic                         is_data;
   logic                         is_check;
   logic                         too_long;
   logic [rlpd_pkg::LEN_W-1:0]   left_dec;
   logic [VALUE_BITS-1:0]        acc_shift;

   // An empty length field makes the current bit a check bit at once.
   assign is_data   = (ctrl_cur.phase == rlpd_pkg::PH_DATA);
   assign is_check  = !is_data &&
                      ((ctrl_cur.phase == rlpd_pkg::PH_CHECK) || (ctrl_cur.bits_left == '0));
   assign too_long  = (ctrl_cur.prefix_value > MaxLen);
   assign left_dec  = ctrl_cur.bits_left - rlpd_pkg::LEN_W'(1);
   assign acc_shift = {acc_cur[VALUE_BITS-2:0], code_bit};

   // Next state.
   always_comb begin
      ctrl_nxt = ctrl_cur;
      acc_nxt  = acc_cur;
      if (!done_cur) begin
         if (is_data) begin
            acc_nxt            = acc_shift;
            ctrl_nxt.bits_left = left_dec;
            if (left_dec == '0) begin
               ctrl_nxt = rlpd_pkg::CTRL_RESTART;
               acc_nxt  = '0;
            end
         end else if (is_check) begin
            if (too_long || (code_bit && (ctrl_cur.prefix_value == '0))) begin
               ctrl_nxt = rlpd_pkg::CTRL_RESTART;
               acc_nxt  = '0;
            end else if (!code_bit) begin
               ctrl_nxt.prefix_value = '0;
               ctrl_nxt.bits_left    = ctrl_cur.prefix_value;
               ctrl_nxt.phase        = (ctrl_cur.prefix_value == '0) ?
                                       rlpd_pkg::PH_CHECK : rlpd_pkg::PH_LENGTH;
            end else begin
               ctrl_nxt.prefix_value = '0;
               ctrl_nxt.data_bits    = ctrl_cur.prefix_value;
               ctrl_nxt.bits_left    = ctrl_cur.prefix_value;
               ctrl_nxt.phase        = rlpd_pkg::PH_DATA;
               acc_nxt               = '0;
            end
         end else begin
            // Length field bit; a field that has passed 63 sticks at the saturation value.
            ctrl_nxt.phase        = rlpd_pkg::PH_LENGTH;
            ctrl_nxt.prefix_value = ctrl_cur.prefix_value[rlpd_pkg::LEN_W-1] ?
                                    rlpd_pkg::PREFIX_SAT :
                                    {ctrl_cur.prefix_value[rlpd_pkg::LEN_W-2:0], code_bit};
            ctrl_nxt.bits_left    = left_dec;
            if (left_dec == '0) begin
               ctrl_nxt.phase = rlpd_pkg::PH_CHECK;
            end
         end
      end
   end

   // Result of the code, taken from the first bit that completes it.
   always_comb begin
      done_nxt  = done_cur;
      value_nxt = value_cur;
      res_nxt   = res_cur;
      if (!done_cur) begin
         if (is_data && (left_dec == '0)) begin
            done_nxt             = 1'b1;
            value_nxt            = acc_shift;
            res_nxt.value_bits   = ctrl_cur.data_bits;
            res_nxt.length_error = 1'b0;
         end else if (is_check && too_long) begin
            done_nxt             = 1'b1;
            value_nxt            = '0;
            res_nxt.value_bits   = '0;
            res_nxt.length_error = 1'b1;
         end else if (is_check && code_bit && (ctrl_cur.prefix_value == '0)) begin
            done_nxt             = 1'b1;
            value_nxt            = '0;
            res_nxt.value_bits   = '0;
            res_nxt.length_error = 1'b0;
         end
      end
   end

endmodule

// ===== sv/rlpd_byte_unit.sv =====
// Chain of eight bit steps that decodes one code byte, most significant bit first.
module rlpd_byte_unit #(
   parameter int VALUE_BITS = 64
) (
   input  rlpd_pkg::ctrl_type      ctrl_cur,
   input  logic [VALUE_BITS-1:0]   acc_cur,
   input  logic [7:0]              code_byte,
   output rlpd_pkg::ctrl_type      ctrl_nxt,
   output logic [VALUE_BITS-1:0]   acc_nxt,
   output logic                    emit,
   output logic [VALUE_BITS-1:0]   value,
   output rlpd_pkg::res_type       res
);

   rlpd_pkg::ctrl_type    ctrl_chain  [9];
   logic [VALUE_BITS-1:0] acc_chain   [9];
   logic                  done_chain  [9];
   logic [VALUE_BITS-1:0] value_chain [9];
   rlpd_pkg::res_type     res_chain   [9];

   assign ctrl_chain[0]  = ctrl_cur;
   assign acc_chain[0]   = acc_cur;
   assign done_chain[0]  = 1'b0;
   assign value_chain[0] = '0;
   assign res_chain[0]   = '0;

   // Once a code completes, later steps pass everything through, which drops the rest of the byte.
   for (genvar i = 0; i < 8; i++) begin : g_step
      rlpd_bit_step #(
         .VALUE_BITS (VALUE_BITS)
      ) u_step (
         .ctrl_cur  (ctrl_chain[i]),
         .acc_cur   (acc_chain[i]),
         .done_cur  (done_chain[i]),
         .value_cur (value_chain[i]),
         .res_cur   (res_chain[i]),
         .code_bit  (code_byte[7-i]),
         .ctrl_nxt  (ctrl_chain[i+1]),
         .acc_nxt   (acc_chain[i+1]),
         .done_nxt  (done_chain[i+1]),
         .value_nxt (value_chain[i+1]),
         .res_nxt   (res_chain[i+1])
      );
   end

   assign ctrl_nxt = ctrl_chain[8];
   assign acc_nxt  = acc_chain[8];
   assign emit     = done_chain[8];
   assign value    = value_chain[8];
   assign res      = res_chain[8];

endmodule

// ===== sv/recursive_length_prefix_decoder.sv =====
// Recursive length prefix decoder: top level with input, state and result registers.
//
// Decodes a stream of length-prefixed integer codes in the Elias omega style, one code byte
// per item, starting each code with a two-bit length field. The block takes one byte every
// clock cycle unless stalled: a byte is held in the input register, and when it advances the
// eight bits pass through a chain of bit steps that update the decoder state and, when a
// code completes or announces a length beyond VALUE_BITS, load the result register. The
// remaining bits of the byte that closes a code are discarded, so every code begins on a
// byte boundary. Stall on the result side holds the result register and then the input
// register, and is passed back to the request side in the same cycle.
module recursive_length_prefix_decoder #(
   parameter int VALUE_BITS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_code_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [VALUE_BITS-1:0]         rsp_decoded_value,
   output logic [rlpd_pkg::LEN_W-1:0]    rsp_value_bits,
   output logic                          rsp_length_error
);

   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             byte_ff;
   rlpd_pkg::ctrl_type     ctrl_ff, ctrl_in;
   logic [VALUE_BITS-1:0]  acc_ff, acc_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0]  value_ff;
   rlpd_pkg::res_type      res_ff;

   logic                   advance;
   logic                   emit;
   logic [VALUE_BITS-1:0]  emit_value;
   rlpd_pkg::res_type      emit_res;
   rlpd_pkg::ctrl_type     ctrl_nxt;
   logic [VALUE_BITS-1:0]  acc_nxt;

   rlpd_byte_unit #(
      .VALUE_BITS (VALUE_BITS)
   ) u_byte_unit (
      .ctrl_cur  (ctrl_ff),
      .acc_cur   (acc_ff),
      .code_byte (byte_ff),
      .ctrl_nxt  (ctrl_nxt),
      .acc_nxt   (acc_nxt),
      .emit      (emit),
      .value     (emit_value),
      .res       (emit_res)
   );

   // The held byte is decoded when the result register is empty or is being emptied.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
      end
   end

   always_comb begin
      ctrl_in = ctrl_ff;
      acc_in  = acc_ff;
      if (advance) begin
         ctrl_in = ctrl_nxt;
         acc_in  = acc_nxt;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = emit;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ctrl_ff      <= rlpd_pkg::CTRL_RESTART;
         acc_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         ctrl_ff      <= ctrl_in;
         acc_ff       <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         byte_ff <= req_code_byte;
      end
      if (advance && emit) begin
         value_ff <= emit_value;
         res_ff   <= emit_res;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_decoded_value = value_ff;
   assign rsp_value_bits    = res_ff.value_bits;
   assign rsp_length_error  = res_ff.length_error;

`include "recursive_length_prefix_decoder_assert.svh"

   `RLPD_ASSERT_IMP(a_error_clears, rsp_valid && rsp_length_error, (rsp_decoded_value == '0) && (rsp_value_bits == '0), "error result carries a non-zero value or bit count")
   `RLPD_ASSERT_IMP(a_bits_in_range, rsp_valid, rsp_value_bits <= rlpd_pkg::LEN_W'(VALUE_BITS), "result bit count exceeds the value width")
   `RLPD_ASSERT_IMP(a_data_count, ctrl_ff.phase == rlpd_pkg::PH_DATA, (ctrl_ff.bits_left != '0) && (ctrl_ff.bits_left <= ctrl_ff.data_bits), "data bit counter out of range")
   `RLPD_ASSERT_IMP(a_data_len_idle, ctrl_ff.phase != rlpd_pkg::PH_DATA, ctrl_ff.data_bits == '0, "data length held outside the data phase")
   `RLPD_ASSERT_NXT(a_stall_holds_byte, req_stall, in_valid_ff && $stable(byte_ff), "held byte lost while the request side was stalled")

endmodule

// ===== bench/tb_recursive_length_prefix_decoder.sv =====
// Testbench for the recursive length prefix decoder: random code streams checked against a predictor.
`timescale 1ns / 1ps

module tb_recursive_length_prefix_decoder;

   localparam int VALUE_BITS   = 64;
   localparam int ITEMS        = 1550;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      logic [VALUE_BITS-1:0]      value;
      logic [rlpd_pkg::LEN_W-1:0] nbits;
      logic                       err;
   } decoded_code_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [7:0]                 req_code_byte = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [VALUE_BITS-1:0]      rsp_decoded_value;
   logic [rlpd_pkg::LEN_W-1:0] rsp_value_bits;
   logic                       rsp_length_error;

   logic [7:0]       code_bytes[$];
   bit               gen_bits[$];
   decoded_code_type expected_codes[$];
   decoded_code_type want;

   int total_items = 0;
   int sent_count  = 0;
   int fail_count  = 0;
   int hold_at     = 0;
   int pause_at    = 0;
   int hold_left   = 0;
   bit hold_done   = 1'b0;
   bit pause_done  = 1'b0;

   // Predicted decoder state.
   rlpd_pkg::phase_type        dec_phase;
   logic [rlpd_pkg::LEN_W-1:0] dec_left;
   logic [rlpd_pkg::LEN_W-1:0] dec_prefix;
   logic [rlpd_pkg::LEN_W-1:0] dec_len;
   logic [VALUE_BITS-1:0]      dec_acc;

   recursive_length_prefix_decoder #(
      .VALUE_BITS(VALUE_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_code_byte    (req_code_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_decoded_value(rsp_decoded_value),
      .rsp_value_bits   (rsp_value_bits),
      .rsp_length_error (rsp_length_error)
   );

   always #10 clock = ~clock;

   task automatic restart_decoder();
      dec_phase  = rlpd_pkg::PH_LENGTH;
      dec_left   = rlpd_pkg::START_LENGTH;
      dec_prefix = '0;
      dec_len    = '0;
      dec_acc    = '0;
   endtask

   task automatic close_code(input logic [VALUE_BITS-1:0] value,
                             input logic [rlpd_pkg::LEN_W-1:0] nbits, input logic err);
      expected_codes.push_back('{value: value, nbits: nbits, err: err});
      restart_decoder();
   endtask

   // Walks the bits of one byte, most significant first; a finished code drops the rest.
   task automatic decode_byte(input logic [7:0] code_byte);
      int                         pos;
      logic                       b;
      logic [rlpd_pkg::LEN_W-1:0] field_len;
      bit                         done;
      pos  = 7;
      done = 1'b0;
      while (pos >= 0 && !done) begin
         b = code_byte[pos];
         case (dec_phase)
            rlpd_pkg::PH_DATA: begin
               dec_acc  = {dec_acc[VALUE_BITS-2:0], b};
               dec_left = dec_left - rlpd_pkg::LEN_W'(1);
               if (dec_left == 0) begin
                  close_code(dec_acc, dec_len, 1'b0);
                  done = 1'b1;
               end
            end
            rlpd_pkg::PH_CHECK: begin
               field_len = dec_prefix;
               if (field_len > VALUE_BITS) begin
                  close_code('0, '0, 1'b1);
                  done = 1'b1;
               end else begin
                  dec_prefix = '0;
                  if (!b) begin
                     dec_left  = field_len;
                     dec_phase = (field_len == 0) ? rlpd_pkg::PH_CHECK : rlpd_pkg::PH_LENGTH;
                  end else if (field_len == 0) begin
                     close_code('0, '0, 1'b0);
                     done = 1'b1;
                  end else begin
                     dec_len   = field_len;
                     dec_left  = field_len;
                     dec_acc   = '0;
                     dec_phase = rlpd_pkg::PH_DATA;
                  end
               end
            end
            default: begin
               dec_phase = rlpd_pkg::PH_LENGTH;
               if (dec_left == 0) begin
                  // An empty field: the same bit is then read again as the check bit.
                  dec_phase = rlpd_pkg::PH_CHECK;
                  pos++;
               end else begin
                  if (dec_prefix > 63) dec_prefix = rlpd_pkg::PREFIX_SAT;
                  else dec_prefix = {dec_prefix[rlpd_pkg::LEN_W-2:0], b};
                  dec_left = dec_left - rlpd_pkg::LEN_W'(1);
                  if (dec_left == 0) dec_phase = rlpd_pkg::PH_CHECK;
               end
            end
         endcase
         pos--;
      end
   endtask

   function automatic longint unsigned rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic int bit_len(input longint unsigned v);
      int n;
      n = 0;
      for (int i = 0; i < 64; i++) if (v[i]) n = i + 1;
      return n;
   endfunction

   task automatic push_bits(input longint unsigned v, input int w);
      for (int i = w - 1; i >= 0; i--) gen_bits.push_back(v[i]);
   endtask

   // Builds the chain of length fields back to the opening two-bit field, then the data.
   task automatic push_code(input longint unsigned len_value, input int width,
                            input bit is_data, input longint unsigned data);
      longint unsigned f_val[$];
      int              f_wid[$];
      bit              f_chk[$];
      longint unsigned t;
      int              w;
      bit              c;
      t = len_value;
      w = width;
      c = is_data;
      forever begin
         f_val.push_front(t);
         f_wid.push_front(w);
         f_chk.push_front(c);
         if (w == rlpd_pkg::START_LENGTH) break;
         t = w;
         c = 1'b0;
         w = bit_len(t);
         if (w < rlpd_pkg::START_LENGTH) w = rlpd_pkg::START_LENGTH;
      end
      foreach (f_val[i]) begin
         push_bits(f_val[i], f_wid[i]);
         gen_bits.push_back(f_chk[i]);
      end
      if (is_data && len_value >= 1 && len_value <= VALUE_BITS)
         push_bits(data, int'(len_value));
   endtask

   // Pads the current code to a whole byte with random bits and queues the bytes.
   task automatic pack_bytes();
      logic [7:0] b;
      while (gen_bits.size() % 8 != 0) gen_bits.push_back(1'($urandom_range(0, 1)));
      while (gen_bits.size() != 0) begin
         for (int i = 7; i >= 0; i--) b[i] = gen_bits.pop_front();
         code_bytes.push_back(b);
      end
   endtask

   task automatic push_random_code();
      int              r;
      int              n;
      int              w;
      int              start_len;
      longint unsigned t;
      longint unsigned d;
      r = $urandom_range(0, 99);
      if (r < 80) begin
         n = $urandom_range(0, 1) ? $urandom_range(0, 12) : $urandom_range(0, VALUE_BITS);
         w = bit_len(n);
         if ($urandom_range(0, 3) == 0) w += $urandom_range(1, 6);
         case ($urandom_range(0, 7))
            0: d = '1;
            1: d = '0;
            default: d = rand64();
         endcase
         start_len = gen_bits.size();
         push_code(n, w, 1'b1, d);
         // A broken code: its tail is lost and the following bits continue it.
         if (r >= 70) repeat ($urandom_range(1, gen_bits.size() - start_len - 1))
            void'(gen_bits.pop_back());
      end else if (r < 92) begin
         w = $urandom_range(7, VALUE_BITS);
         t = rand64();
         if (w < 64) t &= (64'd1 << w) - 1;
         if (t <= VALUE_BITS) t |= 65;
         push_code(t, w, 1'($urandom_range(0, 1)), '0);
      end else begin
         repeat ($urandom_range(1, 3)) code_bytes.push_back(8'($urandom_range(0, 255)));
      end
      pack_bytes();
   endtask

   function automatic int idle_pct(input bit sender);
      if (sent_count < total_items / 3) return sender ? 33 : 69;
      if (sent_count < 2 * total_items / 3) return sender ? 69 : 33;
      return 0;
   endfunction

   // Sender.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) sent_count++;
         if (!pause_done && sent_count >= pause_at && !req_valid && expected_codes.size() == 0)
            pause_done = 1'b1;
         if (!req_valid || !req_stall) begin
            if (code_bytes.size() == 0 || (!pause_done && sent_count >= pause_at) ||
                (hold_left == 0 && $urandom_range(0, 99) < idle_pct(1'b1))) begin
               req_valid <= 1'b0;
            end else begin
               req_valid     <= 1'b1;
               req_code_byte <= code_bytes.pop_front();
            end
         end
      end
   end

   // Receiver, with one long hold-off so that the block backs up into its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && sent_count >= hold_at) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < idle_pct(1'b0));
      end
   end

   // Monitor: predicts from accepted input items and checks accepted results.
   always @(posedge clock) begin
      if (reset) begin
         restart_decoder();
      end else begin
         if (req_valid && !req_stall) decode_byte(req_code_byte);
         if (rsp_valid && !rsp_stall) begin
            if (expected_codes.size() == 0) begin
               $display("%0t: unexpected result, expected none, got value %h bits %0d error %b",
                        $time, rsp_decoded_value, rsp_value_bits, rsp_length_error);
               fail_count++;
            end else begin
               want = expected_codes.pop_front();
               if (rsp_decoded_value !== want.value) begin
                  $display("%0t: decoded_value expected %h, got %h",
                           $time, want.value, rsp_decoded_value);
                  fail_count++;
               end
               if (rsp_value_bits !== want.nbits) begin
                  $display("%0t: value_bits expected %0d, got %0d",
                           $time, want.nbits, rsp_value_bits);
                  fail_count++;
               end
               if (rsp_length_error !== want.err) begin
                  $display("%0t: length_error expected %b, got %b",
                           $time, want.err, rsp_length_error);
                  fail_count++;
               end
            end
         end
      end
   end

   initial begin
      // Directed codes first.
      push_code(0, 2, 1'b1, '0);
      pack_bytes();
      push_code(0, 0, 1'b1, '0);
      pack_bytes();
      push_code(1, 2, 1'b1, 1);
      pack_bytes();
      push_code(1, 1, 1'b1, 0);
      pack_bytes();
      // Twenty-four bits in all, so the code closes on the last bit of its byte.
      push_code(12, 4, 1'b1, rand64());
      pack_bytes();
      push_code(VALUE_BITS, 7, 1'b1, '1);
      pack_bytes();
      push_code(127, 7, 1'b0, '0);
      pack_bytes();
      push_code(65, 7, 1'b1, '0);
      pack_bytes();
      // An eight-bit length field saturates once it passes 63.
      push_code(255, 8, 1'b1, '0);
      pack_bytes();
      code_bytes.push_back(8'h00);
      code_bytes.push_back(8'hFF);
      while (code_bytes.size() < ITEMS) push_random_code();
      total_items = code_bytes.size();
      hold_at     = total_items / 2;
      pause_at    = 5 * total_items / 6;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      while (code_bytes.size() != 0 || req_valid) @(posedge clock);
      while (expected_codes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
